// ===== src/tlpr_pkg.sv =====
package tlpr_pkg;

   // field widths
   localparam int TILE_W   = 8;
   localparam int NUMBER_W = 8;
   localparam int BRIGHT_W = 8;
   localparam int CHAN_W   = 8;
   localparam int COLOR_W  = 3 * CHAN_W;
   localparam int INDEX_W  = 13;
   localparam int PROD_W   = BRIGHT_W + CHAN_W;

   // default geometry of one tile
   localparam int DEFAULT_TILE_PITCH = 20;
   localparam int DEFAULT_TILE_SPAN  = 21;

   // position groups inside a tile
   localparam int SEGMENT_COUNT   = 7;   // positions 0..6: seven-segment digit
   localparam int TENS_END        = 9;   // positions 7..8: tens marker
   localparam int RING_LAST       = 20;  // positions 9..20: edge (odd) / water (even)
   localparam int TENS_THRESHOLD  = 10;
   localparam int DIGIT_COUNT     = 10;

   // segment patterns, bit k lights position k
   localparam logic [SEGMENT_COUNT-1:0] SEG_PATTERN [DIGIT_COUNT] = '{
      7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd7, 7'd127, 7'd111
   };

   typedef struct packed {
      logic [TILE_W-1:0]   tile;
      logic [NUMBER_W-1:0] shown_number;
      logic [BRIGHT_W-1:0] number_brightness;
      logic [COLOR_W-1:0]  number_color;
      logic [BRIGHT_W-1:0] edge_brightness;
      logic [COLOR_W-1:0]  edge_color;
      logic [BRIGHT_W-1:0] water_brightness;
      logic [COLOR_W-1:0]  water_color;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0] pixel_color;
      logic               final_pixel;
   } rsp_type;

   // one pixel leaving the sequencer, before scaling
   typedef struct packed {
      logic                valid;
      logic [BRIGHT_W-1:0] bright;
      logic [COLOR_W-1:0]  color;
      logic [INDEX_W-1:0]  index;
      logic                last;
   } pix_type;

   // tens flag: number of ten or more
   function automatic logic tens_of(input logic [NUMBER_W-1:0] num);
      return num >= NUMBER_W'(TENS_THRESHOLD);
   endfunction

   // segment pattern of the units digit; numbers of twenty or more are blank
   function automatic logic [SEGMENT_COUNT-1:0] digit_pattern(input logic [NUMBER_W-1:0] num);
      logic [NUMBER_W-1:0] digit;
      digit = tens_of(num) ? num - NUMBER_W'(TENS_THRESHOLD) : num;
      if (digit < NUMBER_W'(DIGIT_COUNT)) begin
         return SEG_PATTERN[digit[3:0]];
      end
      return '0;
   endfunction

endpackage

// ===== src/tlpr_seq.sv =====
module tlpr_seq
   import tlpr_pkg::*;
#(
   parameter int TILE_PITCH = DEFAULT_TILE_PITCH,
   parameter int TILE_SPAN  = DEFAULT_TILE_SPAN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    busy,
   output pix_type pix
);

   localparam int POS_W  = $clog2(TILE_SPAN);
   localparam int BASE_W = TILE_W + $clog2(TILE_PITCH + 1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(TILE_SPAN - 1);

   logic                     active_ff, active_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   req_type                  cmd_ff;
   logic [INDEX_W-1:0]       base_ff;
   logic [SEGMENT_COUNT-1:0] pattern_ff;
   logic                     tens_ff;
   pix_type                  pix_ff, pix_in;
   logic                     accept;
   logic                     at_last;
   logic [BASE_W-1:0]        base_full;

   assign at_last = pos_ff == POS_LAST;
   assign busy    = active_ff && !at_last;
   assign accept  = start && !busy;

   assign base_full = BASE_W'(req.tile) * BASE_W'(TILE_PITCH);

   // position counter; a new command loads while the last pixel goes out
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      if (accept) begin
         active_in = 1'b1;
         pos_in    = '0;
      end else if (active_ff) begin
         if (at_last) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // group select for the current position
   always_comb begin
      logic lit_number;
      lit_number    = 1'b0;
      pix_in.valid  = active_ff;
      pix_in.bright = '0;
      pix_in.color  = '0;
      pix_in.index  = base_ff + INDEX_W'(pos_ff);
      pix_in.last   = at_last;
      if (pos_ff < POS_W'(SEGMENT_COUNT)) begin
         lit_number = pattern_ff[pos_ff[2:0]];
      end else if (pos_ff < POS_W'(TENS_END)) begin
         lit_number = tens_ff;
      end else if (pos_ff <= POS_W'(RING_LAST)) begin
         if (pos_ff[0]) begin
            pix_in.bright = cmd_ff.edge_brightness;
            pix_in.color  = cmd_ff.edge_color;
         end else begin
            pix_in.bright = cmd_ff.water_brightness;
            pix_in.color  = cmd_ff.water_color;
         end
      end
      if (lit_number) begin
         pix_in.bright = cmd_ff.number_brightness;
         pix_in.color  = cmd_ff.number_color;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
      end
   end

   // command payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req;
         base_ff    <= INDEX_W'(base_full);
         pattern_ff <= digit_pattern(req.shown_number);
         tens_ff    <= tens_of(req.shown_number);
      end
   end

   // pixel register; only the valid bit is cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff.valid <= 1'b0;
      end else begin
         pix_ff.valid <= pix_in.valid;
      end
      pix_ff.bright <= pix_in.bright;
      pix_ff.color  <= pix_in.color;
      pix_ff.index  <= pix_in.index;
      pix_ff.last   <= pix_in.last;
   end

   assign pix = pix_ff;

endmodule

// ===== src/tlpr_scale.sv =====
module tlpr_scale
   import tlpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  pix_type pix,
   output logic    strobe,
   output rsp_type rsp
);

   // stage 1: brightness times channel
   logic                valid1_ff;
   logic [PROD_W-1:0]   prod_ff [3];
   logic [INDEX_W-1:0]  index1_ff;
   logic                last1_ff;

   // stage 2: divide by 255 and register the result
   logic                valid2_ff;
   rsp_type             rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         prod_ff[c] <= PROD_W'(pix.bright) * PROD_W'(pix.color[c*CHAN_W +: CHAN_W]);
      end
      index1_ff <= pix.index;
      last1_ff  <= pix.last;
   end

   // floor(x/255) = (x + (x >> 8) + 1) >> 8, exact for x up to 255*255
   always_comb begin
      logic [PROD_W:0] sum;
      rsp_in.pixel_index = index1_ff;
      rsp_in.final_pixel = last1_ff;
      rsp_in.pixel_color = '0;
      for (int c = 0; c < 3; c++) begin
         sum = {1'b0, prod_ff[c]} + (PROD_W+1)'(prod_ff[c] >> CHAN_W) + 1'b1;
         rsp_in.pixel_color[c*CHAN_W +: CHAN_W] = sum[CHAN_W +: CHAN_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= pix.valid;
         valid2_ff <= valid1_ff;
      end
   end

   assign strobe = valid2_ff;
   assign rsp    = rsp_ff;

endmodule

// ===== src/tile_led_pattern_renderer.sv =====
// Pipeline: the first pixel write of a command passes the position counter, the pixel
// register, the product and the result register; the following writes come one per cycle,
// TILE_SPAN writes in all. Commands: the single pixel position counter takes one command at
// a time; busy drops during the last position so the next command enters without a gap.
// Reset: synchronous, clears the sequencer and the pipeline valid bits, so pixel writes in
// flight are dropped; the receiver must take every strobed write, the block does not check.
module tile_led_pattern_renderer
   import tlpr_pkg::*;
#(
   parameter int TILE_PITCH = DEFAULT_TILE_PITCH,
   parameter int TILE_SPAN  = DEFAULT_TILE_SPAN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    strobe,
   output rsp_type rsp_data
);

   pix_type pix;

   tlpr_seq #(
      .TILE_PITCH (TILE_PITCH),
      .TILE_SPAN  (TILE_SPAN)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (req_data),
      .busy  (busy),
      .pix   (pix)
   );

   tlpr_scale u_scale (
      .clock  (clock),
      .reset  (reset),
      .pix    (pix),
      .strobe (strobe),
      .rsp    (rsp_data)
   );

   // an accepted command shows its first write after the pipeline depth
   assert property (@(posedge clock) disable iff (reset) start && !busy |-> ##4 strobe)
      else $error("first pixel write missing after command transfer");

   // a fresh command keeps the block busy
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("busy low right after command transfer");

   // pixel writes of one tile run on consecutive indexes
   assert property (@(posedge clock) disable iff (reset)
      strobe && !rsp_data.final_pixel |=>
         strobe && rsp_data.pixel_index == INDEX_W'($past(rsp_data.pixel_index) + 1'b1))
      else $error("pixel write sequence broken");

   // final marks never come back to back
   assert property (@(posedge clock) disable iff (reset)
      strobe && rsp_data.final_pixel |=> !(strobe && rsp_data.final_pixel))
      else $error("final pixel repeated");

endmodule

// ===== bench/tile_led_pattern_renderer_tb.sv =====
module tile_led_pattern_renderer_tb;
   import tlpr_pkg::*;

   localparam int TILE_PITCH   = 20;
   localparam int TILE_SPAN    = 21;
   localparam int RANDOM_CMDS  = 160;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 100;

   // seven-segment glyphs of the units digit, bit k lights position k
   localparam logic [6:0] GLYPH [10] = '{
      7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd7, 7'd127, 7'd111
   };

   typedef struct {
      req_type     cmd;
      int unsigned gap;     // cycles held off before the transfer
      bit          settle;  // wait for every pending pixel write first
   } tile_job_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    strobe;
   rsp_type rsp_data;

   tile_job_type pending_cmds[$];
   rsp_type      pixel_writes_due[$];
   tile_job_type staged_job;
   bit           job_staged = 1'b0;
   int unsigned  hold_left = 0;
   bit           fired = 1'b0;
   int unsigned  mismatch_count = 0;
   int unsigned  idle_cycles = 0;

   tile_led_pattern_renderer dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .strobe   (strobe),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // per-channel floor(bright * channel / 255)
   function automatic logic [COLOR_W-1:0] dim_color(input logic [BRIGHT_W-1:0] bright,
                                                    input logic [COLOR_W-1:0] color);
      logic [COLOR_W-1:0] dimmed;
      logic [PROD_W-1:0]  prod;
      dimmed = '0;
      for (int ch = 0; ch < 3; ch++) begin
         prod = bright * color[ch*CHAN_W +: CHAN_W];
         dimmed[ch*CHAN_W +: CHAN_W] = CHAN_W'(prod / 255);
      end
      return dimmed;
   endfunction

   // all pixel writes one tile command should produce, in order
   function automatic void render_tile(input req_type cmd);
      logic [COLOR_W-1:0] digit_rgb;
      logic [COLOR_W-1:0] rim_rgb;
      logic [COLOR_W-1:0] pool_rgb;
      logic               tens_lit;
      logic [7:0]         units;
      logic [6:0]         glyph;
      rsp_type            px;
      digit_rgb = dim_color(cmd.number_brightness, cmd.number_color);
      rim_rgb   = dim_color(cmd.edge_brightness, cmd.edge_color);
      pool_rgb  = dim_color(cmd.water_brightness, cmd.water_color);
      tens_lit  = cmd.shown_number >= 8'd10;
      units     = tens_lit ? cmd.shown_number - 8'd10 : cmd.shown_number;
      glyph     = (units < 8'd10) ? GLYPH[units[3:0]] : 7'd0;
      for (int p = 0; p < TILE_SPAN; p++) begin
         px.pixel_index = INDEX_W'(cmd.tile * TILE_PITCH + p);
         px.pixel_color = '0;
         if (p < 7) begin
            if (glyph[p]) px.pixel_color = digit_rgb;
         end else if (p < 9) begin
            if (tens_lit) px.pixel_color = digit_rgb;
         end else if (p <= 20) begin
            px.pixel_color = (p % 2 == 1) ? rim_rgb : pool_rgb;
         end
         px.final_pixel = (p == TILE_SPAN - 1);
         pixel_writes_due.push_back(px);
      end
   endfunction

   // brightness biased toward off and full
   function automatic logic [7:0] pick_bright();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // color biased toward black and white
   function automatic logic [23:0] pick_color();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hffffff;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic void queue_cmd(input logic [7:0] tile, input logic [7:0] number,
                                     input int unsigned gap, input bit settle);
      tile_job_type job;
      job.cmd.tile              = tile;
      job.cmd.shown_number      = number;
      job.cmd.number_brightness = pick_bright();
      job.cmd.number_color      = pick_color();
      job.cmd.edge_brightness   = pick_bright();
      job.cmd.edge_color        = pick_color();
      job.cmd.water_brightness  = pick_bright();
      job.cmd.water_color       = pick_color();
      job.gap                   = gap;
      job.settle                = settle;
      pending_cmds.push_back(job);
   endfunction

   // driver: stage the next command, hold it off, then present it until transfer
   always @(negedge clock) begin
      if (!reset && (!start || fired)) begin
         if (!job_staged && pending_cmds.size() > 0) begin
            staged_job = pending_cmds.pop_front();
            hold_left  = staged_job.gap;
            job_staged = 1'b1;
         end
         if (!job_staged) begin
            start <= 1'b0;
         end else if (hold_left > 0) begin
            start <= 1'b0;
            hold_left = hold_left - 1;
         end else if (staged_job.settle && pixel_writes_due.size() > 0) begin
            start <= 1'b0;
         end else begin
            start      <= 1'b1;
            req_data   <= staged_job.cmd;
            job_staged = 1'b0;
         end
      end
   end

   // monitor: check pixel writes, predict on command transfer, watchdog
   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         fired       <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (strobe) begin
            if (pixel_writes_due.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: unexpected pixel write, expected none, actual %0d %06h %0b",
                           $time, rsp_data.pixel_index, rsp_data.pixel_color,
                           rsp_data.final_pixel);
            end else begin
               due = pixel_writes_due.pop_front();
               if (rsp_data.pixel_index !== due.pixel_index
                   || rsp_data.pixel_color !== due.pixel_color
                   || rsp_data.final_pixel !== due.final_pixel) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("%0t: pixel mismatch, expected %0d %06h %0b, actual %0d %06h %0b",
                              $time, due.pixel_index, due.pixel_color, due.final_pixel,
                              rsp_data.pixel_index, rsp_data.pixel_color,
                              rsp_data.final_pixel);
               end
            end
         end
         fired <= start && !busy;
         if (start && !busy) render_tile(req_data);
         if ((start && !busy) || strobe) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tile_led_pattern_renderer regression: fail");
            $finish;
         end
      end
   end

   initial begin
      // directed: every digit, tens range, blank range, tile and color extremes
      for (int n = 0; n < 20; n++) begin
         queue_cmd((n == 0) ? 8'd0 : (n == 19) ? 8'd255 : 8'($urandom),
                   8'(n), $urandom_range(0, 4), n == 5);
      end
      queue_cmd(8'd255, 8'd20, 0, 1'b0);
      queue_cmd(8'($urandom), 8'd99, 1, 1'b0);
      queue_cmd(8'd0, 8'd255, 0, 1'b0);
      // full brightness on white, then zero brightness on white
      pending_cmds[0].cmd.number_brightness = 8'hff;
      pending_cmds[0].cmd.number_color      = 24'hffffff;
      pending_cmds[0].cmd.edge_brightness   = 8'hff;
      pending_cmds[0].cmd.edge_color        = 24'hffffff;
      pending_cmds[0].cmd.water_brightness  = 8'hff;
      pending_cmds[0].cmd.water_color       = 24'hffffff;
      pending_cmds[8].cmd.number_brightness = 8'h00;
      pending_cmds[8].cmd.number_color      = 24'hffffff;
      pending_cmds[8].cmd.edge_brightness   = 8'h00;
      pending_cmds[8].cmd.edge_color        = 24'hffffff;
      pending_cmds[8].cmd.water_brightness  = 8'h00;
      pending_cmds[8].cmd.water_color       = 24'hffffff;

      // random: mostly small numbers, stretches without gaps, periodic drains
      for (int i = 0; i < RANDOM_CMDS; i++) begin
         queue_cmd(8'($urandom),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24)),
                   ((i / 30) % 3 == 1) ? 0 : $urandom_range(0, 4),
                   i % 45 == 44);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the last transfer, then for every pixel write
      @(posedge clock);
      while (pending_cmds.size() > 0 || job_staged || (start && busy)) @(posedge clock);
      @(posedge clock);
      while (pixel_writes_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pixel_writes_due.size() == 0) begin
         $display("tile_led_pattern_renderer regression: pass");
      end else begin
         $display("tile_led_pattern_renderer regression: fail");
      end
      $finish;
   end

endmodule
